>>> sv/servo_angle_to_pwm_count_core_assert.svh
// Assertion shorthands shared by the RTL files.
// Each macro expects clk and rst_n in scope.
`ifndef SERVO_ANGLE_TO_PWM_COUNT_CORE_ASSERT_SVH
`define SERVO_ANGLE_TO_PWM_COUNT_CORE_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define SAPC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SAPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sapc_pkg.sv
package sapc_pkg;

    // Field widths
    localparam int ANGLE_W    = 16;
    localparam int PULSE_W    = 12;
    localparam int PREQ_W     = 16;
    localparam int PULSE_Q8_W = 20;
    localparam int COUNT_W    = 12;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Timing constants
    localparam int FRAME_US         = 20000;
    localparam int PWM_PERIOD       = 4095;
    localparam int PULSE_LIMIT_LOW  = 500;
    localparam int PULSE_LIMIT_HIGH = 2500;

    // Derived datapath widths
    localparam int MIR_W    = ANGLE_W + 2;
    localparam int OFS_W    = ANGLE_W + 1;
    localparam int QUOT_W   = PULSE_W + FRAC_W;
    localparam int NUM_W    = OFS_W + QUOT_W;
    localparam int PERIOD_W = $clog2(PWM_PERIOD + 1);
    localparam int PROD_W   = PULSE_Q8_W + PERIOD_W;
    localparam int Y_W      = PROD_W - FRAC_W;

    // Round-up reciprocal of FRAME_US, exact for every Y_W-bit dividend
    localparam int DEN_W       = $clog2(FRAME_US);
    localparam int RECIP_SHIFT = Y_W + DEN_W;
    localparam int RECIP_W     = RECIP_SHIFT - DEN_W + 2;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + FRAME_US - 1) / FRAME_US;
    localparam int CQ_W      = Y_W + RECIP_W - RECIP_SHIFT;
    localparam int SAT_W     = (CQ_W > COUNT_W) ? CQ_W : COUNT_W;
    localparam int COUNT_MAX = (2 ** COUNT_W) - 1;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ANGLE    = 3'd0,
        REG_CENTRE_ANGLE = 3'd1,
        REG_MAX_ANGLE    = 3'd2,
        REG_MIN_PULSE    = 3'd3,
        REG_CENTRE_PULSE = 3'd4,
        REG_MAX_PULSE    = 3'd5,
        REG_INVERT_DIR   = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        CMD_ANGLE = 1'b0,
        CMD_PULSE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] min_angle;
        logic signed [ANGLE_W-1:0] centre_angle;
        logic signed [ANGLE_W-1:0] max_angle;
        logic [PULSE_W-1:0]        min_pulse;
        logic [PULSE_W-1:0]        centre_pulse;
        logic [PULSE_W-1:0]        max_pulse;
        logic                      invert_dir;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        min_angle:    -16'sd9000,
        centre_angle: 16'sd0,
        max_angle:    16'sd9000,
        min_pulse:    12'd500,
        centre_pulse: 12'd1500,
        max_pulse:    12'd2500,
        invert_dir:   1'b0
    };

    // Classified command: pulse_q8 = lo_pulse*256 + offset*span*256/den
    typedef struct packed {
        logic               bad;
        logic               clamped;
        logic [PULSE_W-1:0] lo_pulse;
        logic [PULSE_W-1:0] span;
        logic [OFS_W-1:0]   offset;
        logic [OFS_W-1:0]   den;
    } item_t;

    // Fields that ride alongside the divider
    typedef struct packed {
        logic               bad;
        logic               clamped;
        logic [PULSE_W-1:0] lo_pulse;
    } side_t;

endpackage

>>> sv/sapc_front.sv
`include "servo_angle_to_pwm_count_core_assert.svh"

module sapc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sapc_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic signed [sapc_pkg::ANGLE_W-1:0] angle_req,
    input  logic [sapc_pkg::PREQ_W-1:0]         pulse_req,
    output logic                                push_valid,
    input  logic                                push_ready,
    output sapc_pkg::item_t                     push_item
);
    import sapc_pkg::*;

    logic                     f1_valid_reg, f1_valid_next;
    cmd_t                     f1_cmd_reg;
    logic signed [MIR_W-1:0]  f1_angle_reg;
    logic [PREQ_W-1:0]        f1_preq_reg;
    logic                     f2_valid_reg, f2_valid_next;
    item_t                    f2_item_reg, f2_item_next;

    logic                     f1_take, f2_take;
    logic signed [MIR_W-1:0]  a_ext, c_ext, mir;
    logic signed [MIR_W-1:0]  min_e, cen_e, max_e;
    logic                     lt, gt, upper;
    logic signed [ANGLE_W-1:0] a_cl, lo_a, hi_a;
    logic signed [OFS_W-1:0]  acl_x, lo_x, hi_x;
    logic [PULSE_W-1:0]       lo_p, hi_p, p_cl;
    logic                     p_lt, p_gt, bad;

    assign f2_take  = !f2_valid_reg || push_ready;
    assign f1_take  = !f1_valid_reg || f2_take;
    assign in_ready = f1_take;

    // Mirror about the centre at full width
    assign a_ext = {{2{angle_req[ANGLE_W-1]}}, angle_req};
    assign c_ext = {{2{cfg.centre_angle[ANGLE_W-1]}}, cfg.centre_angle};
    assign mir   = cfg.invert_dir ? (c_ext + c_ext - a_ext) : a_ext;

    assign f1_valid_next = f1_take ? in_valid : f1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && f1_take)
        begin
            f1_cmd_reg   <= cmd_t'(cmd);
            f1_angle_reg <= mir;
            f1_preq_reg  <= pulse_req;
        end
        if (f1_valid_reg && f2_take)
        begin
            f2_item_reg <= f2_item_next;
        end
    end

    // Clamp, pick the segment and form the interpolation operands
    assign min_e = {{2{cfg.min_angle[ANGLE_W-1]}}, cfg.min_angle};
    assign cen_e = {{2{cfg.centre_angle[ANGLE_W-1]}}, cfg.centre_angle};
    assign max_e = {{2{cfg.max_angle[ANGLE_W-1]}}, cfg.max_angle};

    assign lt    = f1_angle_reg < min_e;
    assign gt    = f1_angle_reg > max_e;
    assign upper = gt || (!lt && (f1_angle_reg > cen_e));

    assign a_cl = lt ? cfg.min_angle : (gt ? cfg.max_angle : f1_angle_reg[ANGLE_W-1:0]);
    assign lo_a = upper ? cfg.centre_angle : cfg.min_angle;
    assign hi_a = upper ? cfg.max_angle : cfg.centre_angle;

    assign acl_x = {a_cl[ANGLE_W-1], a_cl};
    assign lo_x  = {lo_a[ANGLE_W-1], lo_a};
    assign hi_x  = {hi_a[ANGLE_W-1], hi_a};

    assign lo_p = upper ? cfg.centre_pulse : cfg.min_pulse;
    assign hi_p = upper ? cfg.max_pulse : cfg.centre_pulse;

    assign p_lt = f1_preq_reg < PREQ_W'(cfg.min_pulse);
    assign p_gt = f1_preq_reg > PREQ_W'(cfg.max_pulse);
    assign p_cl = p_lt ? cfg.min_pulse
                       : (p_gt ? cfg.max_pulse : f1_preq_reg[PULSE_W-1:0]);

    assign bad = !((cfg.min_angle < cfg.centre_angle) && (cfg.centre_angle < cfg.max_angle))
              || !((cfg.min_pulse < cfg.centre_pulse) && (cfg.centre_pulse < cfg.max_pulse))
              || (cfg.min_pulse < PULSE_W'(PULSE_LIMIT_LOW))
              || (cfg.max_pulse > PULSE_W'(PULSE_LIMIT_HIGH));

    always_comb
    begin
        f2_item_next.bad = bad;
        unique case (f1_cmd_reg)
            CMD_ANGLE:
            begin
                f2_item_next.clamped  = lt || gt;
                f2_item_next.lo_pulse = lo_p;
                f2_item_next.span     = hi_p - lo_p;
                f2_item_next.offset   = acl_x - lo_x;
                f2_item_next.den      = hi_x - lo_x;
            end
            CMD_PULSE:
            begin
                // Direct pulse: zero offset and zero span over a unit denominator
                f2_item_next.clamped  = p_lt || p_gt;
                f2_item_next.lo_pulse = p_cl;
                f2_item_next.span     = '0;
                f2_item_next.offset   = '0;
                f2_item_next.den      = OFS_W'(1);
            end
        endcase
    end

    assign f2_valid_next = f2_take ? f1_valid_reg : f2_valid_reg;

    assign push_valid = f2_valid_reg;
    assign push_item  = f2_item_reg;

    `SAPC_ASSERT_NEXT(a_front_hold, f2_valid_reg && !push_ready,
        f2_valid_reg && $stable(f2_item_reg), "front item lost while queue full")

endmodule

>>> sv/sapc_fifo.sv
`include "servo_angle_to_pwm_count_core_assert.svh"

module sapc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  sapc_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output sapc_pkg::item_t rd_item
);
    import sapc_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               push, pop;

    assign wr_ready = count_reg != (FIFO_AW + 1)'(FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + FIFO_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + FIFO_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (FIFO_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `SAPC_ASSERT_ALWAYS(a_fifo_bound, count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH),
        "queue fill exceeds depth")
    `SAPC_ASSERT_NEXT(a_fifo_drain, pop && !push,
        count_reg == $past(count_reg) - (FIFO_AW + 1)'(1), "queue fill did not drop")
    `SAPC_ASSERT_NEXT(a_fifo_fill, push && !pop,
        count_reg == $past(count_reg) + (FIFO_AW + 1)'(1), "queue fill did not rise")

endmodule

>>> sv/sapc_div.sv
module sapc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [sapc_pkg::NUM_W-1:0]   in_num,
    input  logic [sapc_pkg::OFS_W-1:0]   in_den,
    input  sapc_pkg::side_t              in_side,
    output logic                         out_valid,
    output logic [sapc_pkg::QUOT_W-1:0]  out_quo,
    output sapc_pkg::side_t              out_side
);
    import sapc_pkg::*;

    // One quotient bit per stage, restoring form
    typedef struct packed {
        logic [OFS_W-1:0]  rem;
        logic [QUOT_W-1:0] low;
        logic [QUOT_W-1:0] quo;
        logic [OFS_W-1:0]  den;
        side_t             side;
    } div_stage_t;

    function automatic div_stage_t div_step(input div_stage_t s);
        logic [OFS_W:0] trial;
        logic           ge;
        div_stage_t     r;
        trial   = {s.rem, s.low[QUOT_W-1]};
        ge      = trial >= {1'b0, s.den};
        r       = s;
        r.rem   = ge ? OFS_W'(trial - {1'b0, s.den}) : trial[OFS_W-1:0];
        r.low   = {s.low[QUOT_W-2:0], 1'b0};
        r.quo   = {s.quo[QUOT_W-2:0], ge};
        return r;
    endfunction

    logic [QUOT_W-1:0] valid_reg;
    div_stage_t        st_reg  [QUOT_W];
    div_stage_t        st_next [QUOT_W];
    div_stage_t        st_in;

    always_comb
    begin
        st_in.rem  = in_num[NUM_W-1:QUOT_W];
        st_in.low  = in_num[QUOT_W-1:0];
        st_in.quo  = '0;
        st_in.den  = in_den;
        st_in.side = in_side;
        st_next[0] = div_step(st_in);
        for (int s = 1; s < QUOT_W; s++)
        begin
            st_next[s] = div_step(st_reg[s-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[QUOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < QUOT_W; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign out_quo   = st_reg[QUOT_W-1].quo;
    assign out_side  = st_reg[QUOT_W-1].side;

endmodule

>>> sv/sapc_back.sv
module sapc_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  sapc_pkg::item_t                  pop_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sapc_pkg::COUNT_W-1:0]     pwm_count,
    output logic [sapc_pkg::PULSE_Q8_W-1:0]  pulse_q8,
    output logic                             was_clamped,
    output logic                             config_error
);
    import sapc_pkg::*;

    logic                         adv;

    logic                         m_valid_reg;
    logic [NUM_W-1:0]             m_num_reg;
    logic [OFS_W-1:0]             m_den_reg;
    side_t                        m_side_reg, m_side_next;
    logic [OFS_W+PULSE_W-1:0]     m_prod;

    logic                         d_valid;
    logic [QUOT_W-1:0]            d_quo;
    side_t                        d_side;

    logic                         p_valid_reg;
    logic [PULSE_Q8_W-1:0]        p_pulse_reg, p_pulse_next;
    side_t                        p_side_reg;

    logic                         x_valid_reg;
    logic [PROD_W-1:0]            x_reg, x_next;
    logic [PULSE_Q8_W-1:0]        x_pulse_reg;
    side_t                        x_side_reg;

    logic                         c_valid_reg;
    logic [Y_W+RECIP_W-1:0]       c_prod;
    logic [CQ_W-1:0]              c_reg;
    logic [PULSE_Q8_W-1:0]        c_pulse_reg;
    side_t                        c_side_reg;

    logic                         out_valid_reg;
    logic [COUNT_W-1:0]           out_count_reg, out_count_next;
    logic [PULSE_Q8_W-1:0]        out_pulse_reg;
    logic                         out_clamped_reg, out_bad_reg;
    logic [SAT_W-1:0]             c_ext;

    // Whole back pipeline moves together; it stops only when the output holds
    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;

    assign m_prod = (OFS_W+PULSE_W)'(pop_item.offset) * (OFS_W+PULSE_W)'(pop_item.span);
    assign m_side_next = '{bad: pop_item.bad, clamped: pop_item.clamped,
                           lo_pulse: pop_item.lo_pulse};

    sapc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (m_valid_reg),
        .in_num    (m_num_reg),
        .in_den    (m_den_reg),
        .in_side   (m_side_reg),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    assign p_pulse_next = {d_side.lo_pulse, FRAC_W'(0)} + d_quo;
    assign x_next       = PROD_W'(p_pulse_reg) * PROD_W'(PWM_PERIOD);
    assign c_prod       = (Y_W+RECIP_W)'(x_reg[PROD_W-1:FRAC_W]) * (Y_W+RECIP_W)'(RECIP);

    assign c_ext = SAT_W'(c_reg);
    always_comb
    begin
        if (c_ext > SAT_W'(COUNT_MAX))
        begin
            out_count_next = COUNT_W'(COUNT_MAX);
        end
        else
        begin
            out_count_next = c_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            x_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg   <= pop_valid;
            p_valid_reg   <= d_valid;
            x_valid_reg   <= p_valid_reg;
            c_valid_reg   <= x_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_num_reg       <= {m_prod, FRAC_W'(0)};
            m_den_reg       <= pop_item.den;
            m_side_reg      <= m_side_next;
            p_pulse_reg     <= p_pulse_next;
            p_side_reg      <= d_side;
            x_reg           <= x_next;
            x_pulse_reg     <= p_pulse_reg;
            x_side_reg      <= p_side_reg;
            c_reg           <= c_prod[Y_W+RECIP_W-1:RECIP_SHIFT];
            c_pulse_reg     <= x_pulse_reg;
            c_side_reg      <= x_side_reg;
            // Invalid configuration zeroes every field but the flag
            out_count_reg   <= c_side_reg.bad ? '0 : out_count_next;
            out_pulse_reg   <= c_side_reg.bad ? '0 : c_pulse_reg;
            out_clamped_reg <= c_side_reg.bad ? 1'b0 : c_side_reg.clamped;
            out_bad_reg     <= c_side_reg.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pwm_count    = out_count_reg;
    assign pulse_q8     = out_pulse_reg;
    assign was_clamped  = out_clamped_reg;
    assign config_error = out_bad_reg;

endmodule

>>> sv/servo_angle_to_pwm_count_core.sv
// Servo command to PWM compare count.
//
// Input channel (in_valid/in_ready): one command per transfer. cmd selects
// an angle request (angle_req, hundredths of a degree) or a direct pulse
// request (pulse_req, microseconds). Output channel (out_valid/out_ready):
// one result per command, in order: pwm_count, pulse_q8, was_clamped and
// config_error.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index in the same edge; unknown indexes are dropped. Write only while
// no command is in flight.
// Throughput: one command per cycle while the receiver does not stall. From
// the input transfer to out_valid a command passes the second classify
// stage (the first loads at the transfer), the queue, one multiply stage, a
// 20-stage restoring divider (one quotient bit per stage) and four stages
// for the pulse sum, the count conversion and output.
// When the receiver stalls, the result holds in the output register and the
// whole back end freezes; the front keeps taking commands until its
// 4-entry queue and both classify stages fill, then drops in_ready.
// Reset clears all valid state and loads the default limits; no clearing
// pass is needed, so commands are taken as soon as reset is released.
module servo_angle_to_pwm_count_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sapc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sapc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic signed [sapc_pkg::ANGLE_W-1:0]  angle_req,
    input  logic [sapc_pkg::PREQ_W-1:0]          pulse_req,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sapc_pkg::COUNT_W-1:0]         pwm_count,
    output logic [sapc_pkg::PULSE_Q8_W-1:0]      pulse_q8,
    output logic                                 was_clamped,
    output logic                                 config_error
);
    import sapc_pkg::*;

    cfg_t  cfg_reg, cfg_next;

    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    // Register file decode; writes take effect at the next edge
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_ANGLE:    cfg_next.min_angle    = cfg_data[ANGLE_W-1:0];
                REG_CENTRE_ANGLE: cfg_next.centre_angle = cfg_data[ANGLE_W-1:0];
                REG_MAX_ANGLE:    cfg_next.max_angle    = cfg_data[ANGLE_W-1:0];
                REG_MIN_PULSE:    cfg_next.min_pulse    = cfg_data[PULSE_W-1:0];
                REG_CENTRE_PULSE: cfg_next.centre_pulse = cfg_data[PULSE_W-1:0];
                REG_MAX_PULSE:    cfg_next.max_pulse    = cfg_data[PULSE_W-1:0];
                REG_INVERT_DIR:   cfg_next.invert_dir   = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: mirror, clamp and pick the segment
    sapc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .angle_req  (angle_req),
        .pulse_req  (pulse_req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouple the front from back-end stalls
    sapc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item)
    );

    // Back: interpolate, divide, convert to a compare count
    sapc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pwm_count    (pwm_count),
        .pulse_q8     (pulse_q8),
        .was_clamped  (was_clamped),
        .config_error (config_error)
    );

endmodule

>>> tb/sv/tb_servo_angle_to_pwm_count_core.sv
module tb_servo_angle_to_pwm_count_core;
    import sapc_pkg::*;

    // One result transfer as seen on the output channel.
    typedef struct packed {
        logic [COUNT_W-1:0]    pwm_count;
        logic [PULSE_Q8_W-1:0] pulse_q8;
        logic                  was_clamped;
        logic                  config_error;
    } servo_out_t;

    // Directed rows either send one command or write one register.
    typedef enum logic {
        ROW_SEND  = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
        cmd_t                      op;
        logic signed [ANGLE_W-1:0] ang;
        logic [PREQ_W-1:0]         preq;
        logic                      typed;
        servo_out_t                want;
    } drill_row_t;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    // Results that can be read straight off the default limits:
    // 500 us -> 102, 1500 us -> 307, 2500 us -> 511 counts.
    localparam servo_out_t NO_CHECK       = '0;
    localparam servo_out_t OUT_500        = '{12'd102, 20'd128000, 1'b0, 1'b0};
    localparam servo_out_t OUT_500_CLAMP  = '{12'd102, 20'd128000, 1'b1, 1'b0};
    localparam servo_out_t OUT_1500       = '{12'd307, 20'd384000, 1'b0, 1'b0};
    localparam servo_out_t OUT_2500       = '{12'd511, 20'd640000, 1'b0, 1'b0};
    localparam servo_out_t OUT_2500_CLAMP = '{12'd511, 20'd640000, 1'b1, 1'b0};
    localparam servo_out_t OUT_BAD        = '{12'd0, 20'd0, 1'b0, 1'b1};

    localparam int DRILL_LEN       = 37;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int TAIL_CYCLES     = 40;
    localparam int PRINT_CAP       = 50;

    // Directed sequence, starting from the reset limits (-90..0..90 deg,
    // 500..1500..2500 us, no mirroring). Rows without a typed result go
    // through the predictor.
    localparam drill_row_t DRILL [DRILL_LEN] = '{
        // extremes of the angle field and both segments
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, -16'sd9000, 16'd0, 1'b1, OUT_500},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd9000, 16'd0, 1'b1, OUT_2500},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd0, 16'd0, 1'b1, OUT_1500},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sh8000, 16'd0, 1'b1, OUT_500_CLAMP},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd32767, 16'd0, 1'b1, OUT_2500_CLAMP},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd4500, 16'd0, 1'b1,
          '{12'd409, 20'd512000, 1'b0, 1'b0}},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, -16'sd4500, 16'd0, 1'b1,
          '{12'd204, 20'd256000, 1'b0, 1'b0}},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd1, 16'd0, 1'b0, NO_CHECK},
        // direct pulse requests, clamped at both ends
        '{ROW_SEND, REG_NONE, 16'h0, CMD_PULSE, 16'sd0, 16'd0, 1'b1, OUT_500_CLAMP},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_PULSE, 16'sd0, 16'd65535, 1'b1, OUT_2500_CLAMP},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_PULSE, 16'sd0, 16'd1500, 1'b1, OUT_1500},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_PULSE, 16'sd0, 16'd499, 1'b0, NO_CHECK},
        // mirroring, including a mirror that leaves the 16-bit range
        '{ROW_WRITE, REG_INVERT_DIR, 16'h0001, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd9000, 16'd0, 1'b1, OUT_500},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sh8000, 16'd0, 1'b1, OUT_2500_CLAMP},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, -16'sd1234, 16'd0, 1'b0, NO_CHECK},
        '{ROW_WRITE, REG_CENTRE_ANGLE, 16'd6000, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, -16'sd9000, 16'd0, 1'b0, NO_CHECK},
        '{ROW_WRITE, REG_CENTRE_ANGLE, 16'd0, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_WRITE, REG_INVERT_DIR, 16'h0000, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        // pulse limit below the legal floor
        '{ROW_WRITE, REG_MIN_PULSE, 16'd499, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd0, 16'd0, 1'b1, OUT_BAD},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_PULSE, 16'sd0, 16'd1000, 1'b1, OUT_BAD},
        // junk in the upper data bits of a 12-bit register
        '{ROW_WRITE, REG_MIN_PULSE, 16'hF1F4, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd0, 16'd0, 1'b1, OUT_1500},
        // pulse limit above the legal ceiling
        '{ROW_WRITE, REG_MAX_PULSE, 16'd2501, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_PULSE, 16'sd0, 16'd2000, 1'b1, OUT_BAD},
        '{ROW_WRITE, REG_MAX_PULSE, 16'hA9C4, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        // unknown index: nothing may change, mirroring stays off
        '{ROW_WRITE, REG_NONE, 16'hFFFF, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd9000, 16'd0, 1'b1, OUT_2500},
        // unordered angle limits
        '{ROW_WRITE, REG_CENTRE_ANGLE, 16'd9000, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd0, 16'd0, 1'b1, OUT_BAD},
        '{ROW_WRITE, REG_CENTRE_ANGLE, 16'd0, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        // unordered pulse limits
        '{ROW_WRITE, REG_CENTRE_PULSE, 16'd500, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_PULSE, 16'sd0, 16'd700, 1'b1, OUT_BAD},
        '{ROW_WRITE, REG_CENTRE_PULSE, 16'd1500, CMD_ANGLE, 16'sd0, 16'd0, 1'b0, NO_CHECK},
        '{ROW_SEND, REG_NONE, 16'h0, CMD_ANGLE, 16'sd2250, 16'd0, 1'b0, NO_CHECK}
    };

    // DUT ports; every input is known from time zero
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    cmd_t                      cmd = CMD_ANGLE;
    logic signed [ANGLE_W-1:0] angle_req = '0;
    logic [PREQ_W-1:0]         pulse_req = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [COUNT_W-1:0]        pwm_count;
    logic [PULSE_Q8_W-1:0]     pulse_q8;
    logic                      was_clamped;
    logic                      config_error;

    // Shadow of the limit registers, updated on every write to a known index
    cfg_t limits = '{-16'sd9000, 16'sd0, 16'sd9000, 12'd500, 12'd1500, 12'd2500, 1'b0};

    servo_out_t awaited_results [$];
    int         mismatch_cnt = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;

    servo_angle_to_pwm_count_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .angle_req    (angle_req),
        .pulse_req    (pulse_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pwm_count    (pwm_count),
        .pulse_q8     (pulse_q8),
        .was_clamped  (was_clamped),
        .config_error (config_error)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Map one command onto the applied pulse and its PWM count under the
    // given limits. Work at 64 bits so mirroring and the segment product
    // never wrap.
    function automatic servo_out_t map_command(input cfg_t c, input cmd_t op,
                                               input logic signed [ANGLE_W-1:0] ang,
                                               input logic [PREQ_W-1:0] preq);
        servo_out_t r;
        longint     lo_a;
        longint     mid_a;
        longint     hi_a;
        longint     a;
        longint     seg_a0;
        longint     seg_a1;
        longint     seg_p0;
        longint     seg_p1;
        longint     q8;
        longint     cnt;
        logic       bad;
        r = '0;
        lo_a  = $signed(c.min_angle);
        mid_a = $signed(c.centre_angle);
        hi_a  = $signed(c.max_angle);
        bad = !(lo_a < mid_a && mid_a < hi_a) ||
              !(c.min_pulse < c.centre_pulse && c.centre_pulse < c.max_pulse) ||
              c.min_pulse < PULSE_LIMIT_LOW || c.max_pulse > PULSE_LIMIT_HIGH;
        if (bad)
        begin
            r.config_error = 1'b1;
            return r;
        end
        if (op == CMD_ANGLE)
        begin
            a = $signed(ang);
            if (c.invert_dir)
                a = 2 * mid_a - a;
            if (a < lo_a)
            begin
                a = lo_a;
                r.was_clamped = 1'b1;
            end
            if (a > hi_a)
            begin
                a = hi_a;
                r.was_clamped = 1'b1;
            end
            // the centre angle itself belongs to the lower segment
            if (a <= mid_a)
            begin
                seg_a0 = lo_a;
                seg_a1 = mid_a;
                seg_p0 = c.min_pulse;
                seg_p1 = c.centre_pulse;
            end
            else
            begin
                seg_a0 = mid_a;
                seg_a1 = hi_a;
                seg_p0 = c.centre_pulse;
                seg_p1 = c.max_pulse;
            end
            q8 = seg_p0 * 256 + (a - seg_a0) * (seg_p1 - seg_p0) * 256 / (seg_a1 - seg_a0);
        end
        else
        begin
            q8 = preq;
            if (q8 < c.min_pulse)
            begin
                q8 = c.min_pulse;
                r.was_clamped = 1'b1;
            end
            if (q8 > c.max_pulse)
            begin
                q8 = c.max_pulse;
                r.was_clamped = 1'b1;
            end
            q8 = q8 * 256;
        end
        cnt = q8 * PWM_PERIOD / (longint'(FRAME_US) * 256);
        if (cnt > COUNT_MAX)
            cnt = COUNT_MAX;
        r.pwm_count = cnt[COUNT_W-1:0];
        r.pulse_q8  = q8[PULSE_Q8_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Write one register, then drop the enable before returning so back to
    // back writes never collide on cfg_we. Mirror the write in the shadow;
    // drop it for an unknown index, as the block does.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_ANGLE:    limits.min_angle    = data;
            REG_CENTRE_ANGLE: limits.centre_angle = data;
            REG_MAX_ANGLE:    limits.max_angle    = data;
            REG_MIN_PULSE:    limits.min_pulse    = data[PULSE_W-1:0];
            REG_CENTRE_PULSE: limits.centre_pulse = data[PULSE_W-1:0];
            REG_MAX_PULSE:    limits.max_pulse    = data[PULSE_W-1:0];
            REG_INVERT_DIR:   limits.invert_dir   = data[0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // Load a full set of limits; fill the unused upper data bits with junk.
    task automatic program_limits(input cfg_t c);
        logic [CFG_DATA_W-2:0] junk;
        write_reg(REG_MIN_ANGLE, c.min_angle);
        write_reg(REG_CENTRE_ANGLE, c.centre_angle);
        write_reg(REG_MAX_ANGLE, c.max_angle);
        junk = (CFG_DATA_W-1)'($urandom);
        write_reg(REG_MIN_PULSE, {junk[3:0], c.min_pulse});
        junk = (CFG_DATA_W-1)'($urandom);
        write_reg(REG_CENTRE_PULSE, {junk[3:0], c.centre_pulse});
        junk = (CFG_DATA_W-1)'($urandom);
        write_reg(REG_MAX_PULSE, {junk[3:0], c.max_pulse});
        junk = (CFG_DATA_W-1)'($urandom);
        write_reg(REG_INVERT_DIR, {junk, c.invert_dir});
    endtask

    // Pick the limits for one random phase: fixed extremes first, then
    // random ordered sets, one in five of them broken on purpose.
    task automatic choose_limits(input int ph, output cfg_t c);
        int a0;
        int a1;
        int a2;
        int p0;
        int p1;
        int p2;
        case (ph)
            0: c = '{16'sh8000, 16'sd0, 16'sd32767, 12'd500, 12'd1500, 12'd2500, 1'b0};
            1: c = '{-16'sd18000, 16'sd0, 16'sd18000, 12'd500, 12'd501, 12'd2500, 1'b1};
            2: c = '{-16'sd1, 16'sd0, 16'sd1, 12'd500, 12'd501, 12'd502, 1'b1};
            3: c = '{16'sh8000, 16'sh7FFE, 16'sd32767, 12'd500, 12'd2499, 12'd2500, 1'b1};
            default:
            begin
                a0 = -18000 + int'($urandom_range(35997));
                a1 = a0 + 1 + int'($urandom_range(17998 - a0));
                a2 = a1 + 1 + int'($urandom_range(17999 - a1));
                p0 = 500 + int'($urandom_range(1997));
                p1 = p0 + 1 + int'($urandom_range(2498 - p0));
                p2 = p1 + 1 + int'($urandom_range(2499 - p1));
                c.min_angle    = a0[ANGLE_W-1:0];
                c.centre_angle = a1[ANGLE_W-1:0];
                c.max_angle    = a2[ANGLE_W-1:0];
                c.min_pulse    = p0[PULSE_W-1:0];
                c.centre_pulse = p1[PULSE_W-1:0];
                c.max_pulse    = p2[PULSE_W-1:0];
                c.invert_dir   = 1'($urandom_range(1));
                if ($urandom_range(4) == 0)
                begin
                    case ($urandom_range(3))
                        0: c.centre_angle = c.min_angle;
                        1: c.min_pulse = PULSE_W'($urandom_range(499));
                        2: c.max_pulse = PULSE_W'(2501 + $urandom_range(1594));
                        default: c.centre_pulse = c.max_pulse;
                    endcase
                end
            end
        endcase
    endtask

    // Present one command, hold it until the transfer, then queue what it
    // must produce. Leave in_valid high; the caller drops it for a gap.
    task automatic send_command(input cmd_t op, input logic signed [ANGLE_W-1:0] ang,
                                input logic [PREQ_W-1:0] preq, input logic typed,
                                input servo_out_t want);
        in_valid  <= 1'b1;
        cmd       <= op;
        angle_req <= ang;
        pulse_req <= preq;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_results.push_back(typed ? want : map_command(limits, op, ang, preq));
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Output side: randomize out_ready each cycle and check every result
    // transfer against the oldest queued expectation, field by field.
    always @(posedge clk)
    begin : result_check
        servo_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
                flag_mismatch($sformatf("result with nothing awaited, pwm_count %0d",
                                        pwm_count));
            else
            begin
                want = awaited_results.pop_front();
                if (pwm_count !== want.pwm_count)
                    flag_mismatch($sformatf("pwm_count got %0d, expected %0d",
                                            pwm_count, want.pwm_count));
                if (pulse_q8 !== want.pulse_q8)
                    flag_mismatch($sformatf("pulse_q8 got %0d, expected %0d",
                                            pulse_q8, want.pulse_q8));
                if (was_clamped !== want.was_clamped)
                    flag_mismatch($sformatf("was_clamped got %b, expected %b",
                                            was_clamped, want.was_clamped));
                if (config_error !== want.config_error)
                    flag_mismatch($sformatf("config_error got %b, expected %b",
                                            config_error, want.config_error));
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        cfg_t                      next_limits;
        cmd_t                      op;
        logic signed [ANGLE_W-1:0] ang;
        logic [PREQ_W-1:0]         preq;
        int                        lo_i;
        int                        hi_i;
        int                        span;
        int                        ang_i;
        int                        p_i;

        // Reset once.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: walk the table back to back with no stalls.
        // Drain the pipe before every register write.
        for (int i = 0; i < DRILL_LEN; i++)
        begin
            if (DRILL[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(DRILL[i].idx, DRILL[i].data);
            end
            else
                send_command(DRILL[i].op, DRILL[i].ang, DRILL[i].preq,
                             DRILL[i].typed, DRILL[i].want);
        end

        // Random part: each phase reloads the limits while idle, then runs
        // one idling pattern: none, sender gaps, receiver stalls, or both.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            choose_limits(ph, next_limits);
            program_limits(next_limits);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 65;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct = 38;
                    stall_pct = 38;
                end
            endcase

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Halfway through, let the pipe run dry before going on.
                if (k == ITEMS_PER_PHASE / 2)
                    drain_results();

                op = cmd_t'($urandom_range(1));

                // Angles: mostly around the configured range, some near the
                // centre, some anywhere in the 16-bit field.
                lo_i = $signed(limits.min_angle);
                hi_i = $signed(limits.max_angle);
                span = (hi_i > lo_i) ? hi_i - lo_i : 0;
                case ($urandom_range(9))
                    0, 1, 2: ang_i = int'($urandom_range(65535));
                    3, 4:    ang_i = $signed(limits.centre_angle) + int'($urandom_range(64)) - 32;
                    default: ang_i = lo_i - 300 + int'($urandom_range(span + 600));
                endcase
                ang = ang_i[ANGLE_W-1:0];

                // Pulses: mostly near the limits, some anywhere.
                span = (limits.max_pulse > limits.min_pulse) ?
                       int'(limits.max_pulse) - int'(limits.min_pulse) : 0;
                if ($urandom_range(9) < 3)
                    p_i = int'($urandom_range(65535));
                else
                    p_i = int'(limits.min_pulse) - 50 + int'($urandom_range(span + 100));
                preq = p_i[PREQ_W-1:0];

                send_command(op, ang, preq, 1'b0, NO_CHECK);

                // Sender gap: drop valid for a random, geometrically distributed gap.
                if ($urandom_range(99) < send_idle_pct)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while ($urandom_range(99) < send_idle_pct);
                end
            end
        end

        // Wind down: free the output, wait for the last result, then watch
        // a little longer for anything extra.
        stall_pct = 0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
